/* rtl/core/circle_overlap_layer_filter_unit_defines.svh */
// Assertion macros for the circle overlap layer filter unit.
`ifndef CIRCLE_OVERLAP_LAYER_FILTER_UNIT_DEFINES_SVH
`define CIRCLE_OVERLAP_LAYER_FILTER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define COLF_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define COLF_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define COLF_ASSERT(label, clk, rst_n, prop, msg)
`define COLF_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

/* rtl/core/colf_pkg.sv */
// Shared types and constants for the circle overlap layer filter unit.
`default_nettype none
package colf_pkg;
	localparam int MAX_AGENTS_DEF = 64;
	localparam int COORD_BITS = 16;
	localparam int CMD_W = 2;
	localparam int IDX_W = 6;
	localparam int RAD_W = 15;
	localparam int LAYER_W = 32;

	typedef enum logic [CMD_W-1:0] {
		CMD_PLACE = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_RUN   = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0]                 command;
		logic [IDX_W-1:0]           slot_index;
		logic signed [COORD_BITS-1:0] pos_x;
		logic signed [COORD_BITS-1:0] pos_y;
		logic [RAD_W-1:0]           radius;
		logic [LAYER_W-1:0]         own_layer;
		logic [LAYER_W-1:0]         hit_mask;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0] slot;
		logic             occupied;
		logic             hit;
		logic             last;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAIR,
		ST_DRAIN,
		ST_EMIT,
		ST_WAIT
	} be_state_t;
endpackage
`default_nettype wire

/* rtl/core/colf_cmd_queue.sv */
// Front part: accepts commands, filters dead ones, queues them for the engine.
`default_nettype none
module colf_cmd_queue #(
	parameter int MAX_AGENTS = 64
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	output logic                 full,
	input  colf_pkg::in_item_t   in_item,
	output logic                 q_valid,
	input  wire                  q_take,
	output colf_pkg::in_item_t   q_item
);
	import colf_pkg::*;
	`include "circle_overlap_layer_filter_unit_defines.svh"

	localparam int DEPTH = 2;

	in_item_t  buf_q [DEPTH];
	logic      wr_q, rd_q;
	logic [1:0] cnt_q;
	logic      keep;
	logic      acc;

	// slots beyond the table and unused codes are dropped here
	always_comb begin
		unique case (cmd_t'(in_item.command))
			CMD_PLACE, CMD_CLEAR: keep = (32'(in_item.slot_index) < 32'(MAX_AGENTS));
			CMD_RUN:              keep = 1'b1;
			default:              keep = 1'b0;
		endcase
	end

	assign full    = (cnt_q == 2'(DEPTH));
	assign acc     = push && !full;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item  = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (acc && keep)
			buf_q[wr_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (acc && keep)
				wr_q <= ~wr_q;
			if (q_take && q_valid)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(acc && keep) - 2'(q_take && q_valid);
		end
	end

	`COLF_NEVER(a_no_overflow, clk, arst_n, cnt_q > 2'(DEPTH), "queue count overflow")
	`COLF_NEVER(a_no_underflow, clk, arst_n, (cnt_q == 2'd0) && q_take && q_valid,
		"pop from empty queue")
	`COLF_ASSERT(a_cnt_step, clk, arst_n,
		(acc && keep && !(q_take && q_valid)) |=> (cnt_q == $past(cnt_q) + 2'd1),
		"count did not follow write")
endmodule
`default_nettype wire

/* rtl/core/colf_pair_unit.sv */
// Pair test: eligibility and exact circle overlap, two registered stages.
`default_nettype none
module colf_pair_unit (
	input  wire                               clk,
	input  wire                               in_valid,
	input  wire [colf_pkg::COORD_BITS-1:0]    ax,
	input  wire [colf_pkg::COORD_BITS-1:0]    ay,
	input  wire [colf_pkg::RAD_W-1:0]         ar,
	input  wire [colf_pkg::LAYER_W-1:0]       amask,
	input  wire [colf_pkg::COORD_BITS-1:0]    bx,
	input  wire [colf_pkg::COORD_BITS-1:0]    by,
	input  wire [colf_pkg::RAD_W-1:0]         br,
	input  wire [colf_pkg::LAYER_W-1:0]       blayer,
	output logic                              hit
);
	import colf_pkg::*;

	localparam int DW = COORD_BITS + 1;
	localparam int SW = 2 * DW + 1;

	logic [DW-1:0]      ux_s1, uy_s1;
	logic [RAD_W:0]     rs_s1;
	logic               ok_s1;
	logic signed [DW-1:0] dx, dy;
	logic [SW-1:0]      d2;
	logic [SW-1:0]      r2;

	assign dx = DW'($signed(ax)) - DW'($signed(bx));
	assign dy = DW'($signed(ay)) - DW'($signed(by));

	always_ff @(posedge clk) begin
		ux_s1 <= dx[DW-1] ? DW'(-dx) : DW'(dx);
		uy_s1 <= dy[DW-1] ? DW'(-dy) : DW'(dy);
		rs_s1 <= (RAD_W+1)'(ar) + (RAD_W+1)'(br);
		ok_s1 <= in_valid && ((amask & blayer) != '0);
	end

	assign d2 = SW'(ux_s1) * SW'(ux_s1) + SW'(uy_s1) * SW'(uy_s1);
	assign r2 = SW'(rs_s1) * SW'(rs_s1);

	always_ff @(posedge clk) begin
		hit <= ok_s1 && (d2 < r2);
	end
endmodule
`default_nettype wire

/* rtl/core/colf_engine.sv */
// Back part: agent table, pair sweep over the table and result emission.
`default_nettype none
module colf_engine #(
	parameter int MAX_AGENTS = 64
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  q_valid,
	output logic                 q_take,
	input  colf_pkg::in_item_t   q_item,
	output logic                 empty,
	input  wire                  pop,
	output colf_pkg::out_item_t  out_item
);
	import colf_pkg::*;
	`include "circle_overlap_layer_filter_unit_defines.svh"

	localparam int AW = (MAX_AGENTS > 1) ? $clog2(MAX_AGENTS) : 1;

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [RAD_W-1:0]      r;
		logic [LAYER_W-1:0]    layer;
		logic [LAYER_W-1:0]    mask;
	} agent_t;

	// two copies: row agent and column agent read at separate addresses
	agent_t mem_a [MAX_AGENTS];
	agent_t mem_b [MAX_AGENTS];
	agent_t ra_q, rb_q;

	logic [MAX_AGENTS-1:0] valid_q, hitf_q;
	be_state_t state_q, state_d;
	logic [AW-1:0] row_q, col_q;
	logic [AW-1:0] rb_idx_s1, ra_idx_s1;
	logic          rd_go_s1, pr_go_s2, pr_go_s3;
	logic [AW-1:0] pa_s2, pb_s2, pa_s3, pb_s3;
	logic [1:0]    drain_q;
	logic          pair_hit;
	logic          rd_go;
	logic          wr_en;
	agent_t        wr_data;
	logic          row_last, col_last;
	logic          out_v_q;
	out_item_t     out_q;
	logic [AW-1:0] emit_q;
	logic [AW-1:0] q_slot;

	assign q_slot = AW'(q_item.slot_index);
	assign wr_en = (state_q == ST_IDLE) && q_valid
		&& (cmd_t'(q_item.command) == CMD_PLACE);
	assign wr_data = '{x: COORD_BITS'(q_item.pos_x), y: COORD_BITS'(q_item.pos_y),
		r: q_item.radius, layer: q_item.own_layer, mask: q_item.hit_mask};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_a[q_slot] <= wr_data;
			mem_b[q_slot] <= wr_data;
		end
		ra_q <= mem_a[row_q];
		rb_q <= mem_b[col_q];
	end

	assign row_last = (row_q == AW'(MAX_AGENTS - 1));
	assign col_last = (col_q == AW'(MAX_AGENTS - 1));
	assign rd_go = (state_q == ST_PAIR) && valid_q[row_q] && valid_q[col_q]
		&& (row_q != col_q);

	colf_pair_unit u_pair (
		.clk     (clk),
		.in_valid(rd_go_s1 && (ra_q.mask != '0)),
		.ax      (ra_q.x), .ay(ra_q.y), .ar(ra_q.r), .amask(ra_q.mask),
		.bx      (rb_q.x), .by(rb_q.y), .br(rb_q.r), .blayer(rb_q.layer),
		.hit     (pair_hit)
	);

	always_comb begin
		state_d = state_q;
		q_take  = 1'b0;
		unique case (state_q)
			ST_IDLE: if (q_valid) begin
				q_take = 1'b1;
				if (cmd_t'(q_item.command) == CMD_RUN)
					state_d = ST_PAIR;
			end
			ST_PAIR:  if (row_last && col_last) state_d = ST_DRAIN;
			ST_DRAIN: if (drain_q == 2'd3) state_d = ST_EMIT;
			ST_EMIT:  if (!out_v_q || pop) state_d = ST_WAIT;
			ST_WAIT: begin
				if (!out_v_q || pop) begin
					if (emit_q == AW'(MAX_AGENTS - 1))
						state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		rb_idx_s1 <= col_q;
		ra_idx_s1 <= row_q;
		pa_s2 <= ra_idx_s1;
		pb_s2 <= rb_idx_s1;
		pa_s3 <= pa_s2;
		pb_s3 <= pb_s2;
	end

	assign empty = !out_v_q;
	assign out_item = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			valid_q  <= '0;
			hitf_q   <= '0;
			row_q    <= '0;
			col_q    <= '0;
			drain_q  <= '0;
			rd_go_s1 <= 1'b0;
			pr_go_s2 <= 1'b0;
			pr_go_s3 <= 1'b0;
			out_v_q  <= 1'b0;
			out_q    <= '0;
			emit_q   <= '0;
		end else begin
			state_q  <= state_d;
			rd_go_s1 <= rd_go;
			pr_go_s2 <= rd_go_s1;
			pr_go_s3 <= pr_go_s2;
			if (pop && out_v_q)
				out_v_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (q_valid) begin
					unique case (cmd_t'(q_item.command))
						CMD_PLACE: begin
							valid_q[q_slot] <= 1'b1;
							hitf_q[q_slot]  <= 1'b0;
						end
						CMD_CLEAR: begin
							valid_q[q_slot] <= 1'b0;
							hitf_q[q_slot]  <= 1'b0;
						end
						CMD_RUN: begin
							hitf_q <= '0;
							row_q  <= '0;
							col_q  <= '0;
						end
						default: ;
					endcase
				end
				ST_PAIR: begin
					col_q <= col_q + AW'(1);
					if (col_last) begin
						col_q <= '0;
						row_q <= row_q + AW'(1);
					end
					drain_q <= '0;
				end
				ST_DRAIN: begin
					drain_q <= drain_q + 2'd1;
					emit_q  <= '0;
				end
				ST_EMIT, ST_WAIT: begin
					if (!out_v_q || pop) begin
						out_v_q <= 1'b1;
						out_q   <= '{slot: IDX_W'(emit_q), occupied: valid_q[emit_q],
							hit: valid_q[emit_q] && hitf_q[emit_q],
							last: (emit_q == AW'(MAX_AGENTS - 1))};
						if (state_q == ST_WAIT || state_d == ST_WAIT)
							emit_q <= emit_q + AW'(1);
					end
				end
				default: ;
			endcase
			if (pr_go_s3 && pair_hit) begin
				hitf_q[pa_s3] <= 1'b1;
				hitf_q[pb_s3] <= 1'b1;
			end
		end
	end

	`COLF_NEVER(a_no_take_busy, clk, arst_n, q_take && (state_q != ST_IDLE),
		"command taken while engine busy")
	`COLF_NEVER(a_no_write_busy, clk, arst_n, wr_en && (state_q != ST_IDLE),
		"table written during a run")
	`COLF_ASSERT(a_out_hold, clk, arst_n, (out_v_q && !pop) |=> (out_v_q && $stable(out_q)),
		"waiting result changed")
endmodule
`default_nettype wire

/* rtl/core/circle_overlap_layer_filter_unit.sv */
// Top level of the circle overlap layer filter unit.
//  channel | handshake      | payload
//  command | push / full    | in_item  (colf_pkg::in_item_t)
//  result  | empty / pop    | out_item (colf_pkg::out_item_t)
// Place and clear: one beat a cycle while the engine is idle; each is queued, then applied
// when the engine takes it. A run sweeps all MAX_AGENTS^2 ordered pairs with one pair unit,
// one pair a cycle, lets the pair pipeline drain, then emits MAX_AGENTS results,
// one a cycle when pop keeps up.
// Reset clears occupancy and hit flags at once; agent data is not cleared.
// A waiting result holds emission; the command queue keeps taking items until full.
`default_nettype none
module circle_overlap_layer_filter_unit #(
	parameter int MAX_AGENTS = colf_pkg::MAX_AGENTS_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	output logic                 full,
	input  colf_pkg::in_item_t   in_item,
	output logic                 empty,
	input  wire                  pop,
	output colf_pkg::out_item_t  out_item
);
	import colf_pkg::*;

	logic     q_valid, q_take;
	in_item_t q_item;

	colf_cmd_queue #(.MAX_AGENTS(MAX_AGENTS)) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_item(in_item),
		.q_valid(q_valid), .q_take(q_take), .q_item(q_item)
	);

	colf_engine #(.MAX_AGENTS(MAX_AGENTS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_take(q_take),
		.q_item(q_item), .empty(empty), .pop(pop), .out_item(out_item)
	);
endmodule
`default_nettype wire

/* bench/circle_overlap_layer_filter_unit_test.sv */
// Testbench for the circle overlap layer filter unit: command stream, detection runs, scoreboard.
`default_nettype none

class overlap_scoreboard;
	bit                  occupied_tbl[64];
	logic signed [15:0]  x_tbl[64];
	logic signed [15:0]  y_tbl[64];
	logic [14:0]         r_tbl[64];
	logic [31:0]         layer_tbl[64];
	logic [31:0]         mask_tbl[64];
	colf_pkg::out_item_t pending_results[$];
	int                  mismatches;

	function bit circles_touch(int a, int b);
		longint dx, dy, rs;
		dx = longint'(x_tbl[a]) - longint'(x_tbl[b]);
		dy = longint'(y_tbl[a]) - longint'(y_tbl[b]);
		rs = longint'(r_tbl[a]) + longint'(r_tbl[b]);
		return (dx * dx + dy * dy) < rs * rs;
	endfunction

	function void note_command(colf_pkg::in_item_t it);
		bit hits[64];
		colf_pkg::out_item_t res;
		case (it.command)
			colf_pkg::CMD_PLACE: begin
				occupied_tbl[it.slot_index] = 1;
				x_tbl[it.slot_index] = it.pos_x;
				y_tbl[it.slot_index] = it.pos_y;
				r_tbl[it.slot_index] = it.radius;
				layer_tbl[it.slot_index] = it.own_layer;
				mask_tbl[it.slot_index] = it.hit_mask;
			end
			colf_pkg::CMD_CLEAR: occupied_tbl[it.slot_index] = 0;
			colf_pkg::CMD_RUN: begin
				for (int a = 0; a < 64; a++) begin
					if (!occupied_tbl[a] || mask_tbl[a] == 0) continue;
					for (int b = 0; b < 64; b++) begin
						if (b == a || !occupied_tbl[b]) continue;
						if ((mask_tbl[a] & layer_tbl[b]) == 0) continue;
						if (circles_touch(a, b)) begin
							hits[a] = 1;
							hits[b] = 1;
						end
					end
				end
				for (int a = 0; a < 64; a++) begin
					res.slot = a[5:0];
					res.occupied = occupied_tbl[a];
					res.hit = occupied_tbl[a] && hits[a];
					res.last = (a == 63);
					pending_results.insert(pending_results.size(), res);
				end
			end
			default: ;
		endcase
	endfunction

	function void check_result(colf_pkg::out_item_t got);
		colf_pkg::out_item_t want;
		if (pending_results.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected result beat %p", got);
			return;
		end
		want = pending_results.pop_front();
		if (got.slot !== want.slot || got.occupied !== want.occupied ||
				got.hit !== want.hit || got.last !== want.last) begin
			mismatches++;
			if (mismatches <= 10) $display("result mismatch: expected %p, got %p", want, got);
		end
	endfunction
endclass

module circle_overlap_layer_filter_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 0;
	logic arst_n = 0;
	logic push = 0;
	logic pop = 0;
	logic full, empty;
	colf_pkg::in_item_t in_item = '0;
	colf_pkg::out_item_t out_item;
	int send_idle_pct = 15;
	int recv_idle_pct = 45;
	overlap_scoreboard board = new();

	circle_overlap_layer_filter_unit u_top (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_item(in_item),
		.empty(empty), .pop(pop), .out_item(out_item)
	);

	always #5 clk = ~clk;

	// receiver: random pop, check on accepted beat
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) board.check_result(out_item);
			pop <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// push stays high after a beat; an idle cycle lowers it, the next beat replaces the item
	task automatic send_beat(colf_pkg::in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 0;
			@(posedge clk);
		end
		push <= 1;
		in_item <= it;
		@(posedge clk);
		while (full) @(posedge clk);
		board.note_command(it);
	endtask

	function automatic colf_pkg::in_item_t make_place(int slot, int clustered);
		colf_pkg::in_item_t it;
		it.command = colf_pkg::CMD_PLACE;
		it.slot_index = slot[5:0];
		if (clustered) begin
			it.pos_x = 16'($signed($urandom_range(2000)) - 1000);
			it.pos_y = 16'($signed($urandom_range(2000)) - 1000);
			it.radius = 15'($urandom_range(700));
			it.own_layer = 32'(1) << $urandom_range(3);
			it.hit_mask = ($urandom_range(9) == 0) ? 32'd0 : 32'($urandom_range(15));
		end else begin
			it.pos_x = 16'($urandom);
			it.pos_y = 16'($urandom);
			it.radius = 15'($urandom);
			it.own_layer = $urandom;
			it.hit_mask = $urandom;
		end
		return it;
	endfunction

	function automatic colf_pkg::in_item_t make_cmd(colf_pkg::cmd_t c, int slot);
		colf_pkg::in_item_t it;
		it = '0;
		it.command = c;
		it.slot_index = slot[5:0];
		it.pos_x = 16'($urandom);
		it.radius = 15'($urandom);
		it.own_layer = $urandom;
		return it;
	endfunction

	task automatic directed_part();
		colf_pkg::in_item_t it;
		send_beat(make_cmd(colf_pkg::CMD_RUN, 0));
		// extremes: opposite corners, full radius, all layers
		it = make_cmd(colf_pkg::CMD_PLACE, 0);
		it.pos_x = 16'sh8000; it.pos_y = 16'sh8000; it.radius = 15'h7fff;
		it.own_layer = '1; it.hit_mask = '1;
		send_beat(it);
		it.slot_index = 6'd63; it.pos_x = 16'sh7fff; it.pos_y = 16'sh7fff;
		send_beat(it);
		send_beat(make_cmd(colf_pkg::CMD_RUN, 0));
		// exact tangency is no hit; mask zero never initiates
		it.slot_index = 6'd63; it.pos_x = 16'sd0; it.pos_y = 16'sd0; it.radius = 15'd10;
		it.own_layer = 32'h1; it.hit_mask = 32'h2;
		send_beat(it);
		it.slot_index = 6'd5; it.pos_x = 16'sd20; it.radius = 15'd10;
		it.own_layer = 32'h2; it.hit_mask = 32'h0;
		send_beat(it);
		it.slot_index = 6'd0; it.pos_x = 16'sh8000; it.pos_y = 16'sh8000; it.radius = 15'd0;
		send_beat(it);
		send_beat(make_cmd(colf_pkg::CMD_RUN, 0));
		it.slot_index = 6'd5; it.pos_x = 16'sd19; it.hit_mask = 32'h0;   // overwrite, now overlapping
		send_beat(it);
		send_beat(make_cmd(colf_pkg::CMD_RUN, 0));
		// layer outside the other mask: overlapping neighbor stays unmarked
		it.slot_index = 6'd6; it.pos_x = 16'sd0; it.pos_y = 16'sd5;
		it.own_layer = 32'h8; it.hit_mask = 32'h0;
		send_beat(it);
		send_beat(make_cmd(colf_pkg::CMD_NONE, 6));
		send_beat(make_cmd(colf_pkg::CMD_CLEAR, 5));
		send_beat(make_cmd(colf_pkg::CMD_CLEAR, 40));
		send_beat(make_cmd(colf_pkg::CMD_RUN, 0));
	endtask

	task automatic random_part(int items);
		int slot;
		colf_pkg::cmd_t c;
		for (int i = 0; i < items; i++) begin
			slot = $urandom_range(63);
			case ($urandom_range(19))
				0, 1: c = colf_pkg::CMD_CLEAR;
				2: c = colf_pkg::CMD_RUN;
				3: c = colf_pkg::CMD_NONE;
				default: c = colf_pkg::CMD_PLACE;
			endcase
			if (c == colf_pkg::CMD_PLACE) send_beat(make_place(slot, $urandom_range(3) != 0));
			else send_beat(make_cmd(c, slot));
			if (i == items / 2) begin
				// hold off until all results are in
				push <= 0;
				@(posedge clk);
				while (board.pending_results.size() != 0) @(posedge clk);
			end
		end
		send_beat(make_cmd(colf_pkg::CMD_RUN, 0));
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		directed_part();
		random_part(150);
		send_idle_pct = 45; recv_idle_pct = 15;
		random_part(150);
		send_idle_pct = 0; recv_idle_pct = 0;
		random_part(150);
		push <= 0;
		@(posedge clk);
		while (board.pending_results.size() != 0) @(posedge clk);
		repeat (8500) @(posedge clk);
		if (board.mismatches == 0 && board.pending_results.size() == 0)
			$display("circle_overlap_layer_filter_unit_test OK");
		else
			$display("circle_overlap_layer_filter_unit_test NOT OK");
		$finish;
	end

	initial begin
		#60ms;
		$display("circle_overlap_layer_filter_unit_test NOT OK");
		$finish;
	end
endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/colf_pkg.sv
rtl/core/colf_cmd_queue.sv
rtl/core/colf_pair_unit.sv
rtl/core/colf_engine.sv
rtl/core/circle_overlap_layer_filter_unit.sv
bench/circle_overlap_layer_filter_unit_test.sv
